// ----- rtl/graph_shortest_distance_top_assert.svh -----
// assertion macros for the shortest distance block
`ifndef GRAPH_SHORTEST_DISTANCE_TOP_ASSERT_SVH
`define GRAPH_SHORTEST_DISTANCE_TOP_ASSERT_SVH

// checked property with reset disable
`define GSD_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("gsd assertion failed");

// checked property that also holds through reset
`define GSD_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("gsd assertion failed");

`endif

// ----- rtl/gsd_pkg.sv -----
// shared types, constants and helpers for the shortest distance block
package gsd_pkg;

  localparam int MAX_FACES = 1024;
  localparam int FACE_W    = 10;
  localparam int MAX_NB    = 12;
  localparam int SLOT_W    = 4;
  localparam int COORD_W   = 24;
  localparam int DIST_W    = 32;
  localparam int CNT_W     = 11;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int NB_ADDR_W = FACE_W + SLOT_W;
  localparam int NB_DEPTH  = 1 << NB_ADDR_W;
  localparam int NB_ENT_W  = FACE_W + 1;
  localparam int DENT_W    = DIST_W + 2;
  localparam int BARI_W    = 3 * COORD_W;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  typedef enum logic [1:0] {
    KIND_LOAD_BARI = 2'd0,
    KIND_LOAD_NB   = 2'd1,
    KIND_RUN       = 2'd2,
    KIND_READ      = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_RUN_CLR,
    ST_RUN_START,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MARK,
    ST_CUR_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_FETCH,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_RELAX
  } state_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [FACE_W-1:0]         face_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [SLOT_W-1:0]         slot;
    logic [FACE_W-1:0]         neighbor_index;
    logic                      neighbor_valid;
  } gsd_in_t;

  typedef struct packed {
    logic [FACE_W-1:0] result_face;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              status;
  } gsd_out_t;

  typedef struct packed {
    logic              reached;
    logic              visited;
    logic [DIST_W-1:0] path_len;
  } dist_ent_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

// ----- rtl/gsd_ram.sv -----
// generic single write port ram with registered read
module gsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gsd_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module gsd_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  gsd_pkg::sqrt_req_t req,
  output gsd_pkg::sqrt_rsp_t rsp
);
  import gsd_pkg::*;

  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] res_r, res_nxt;
  logic [SUM_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.radicand;
      res_nxt  = '0;
      bit_nxt  = SUM_W'(1) << (SUM_W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == SUM_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[ROOT_W-1:0];

endmodule

// ----- rtl/graph_shortest_distance_top.sv -----
// top level of the single source shortest distance block
// usage:
//   in_* carries one transaction per item: load baricenter, load neighbor slot,
//   run from a face, or read a face distance; out_* returns one result each.
//   cfg_* writes face_count; the user must write only while the block is idle (unchecked).
// sequencing and throughput:
//   loads and rejected items give their result in the cycle after acceptance;
//   a good read passes through the read wait state, where the ram word becomes the result.
//   a run clears the distance ram, then repeats a scan of the faces to pick the
//   next face, marks it, and works through its neighbor slots, a filled one
//   through the shared squarer and bit serial square root, an empty one skipped.
//   one item is in work at a time; in_ready is low while it runs.
// reset:
//   a clearing pass sweeps the neighbor ram and the distance ram; no item is
//   taken meanwhile, cfg writes are.
// stall:
//   a held result stays in the output register; the next item is taken
//   in the cycle the result leaves.
module graph_shortest_distance_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gsd_pkg::gsd_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gsd_pkg::gsd_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gsd_pkg::CNT_W-1:0]      cfg_data
);
  import gsd_pkg::*;

  state_t                   state_r, state_nxt;
  logic [NB_ADDR_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]         face_i_r, face_i_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic                     found_r, found_nxt;
  logic [FACE_W-1:0]        best_face_r, best_face_nxt;
  logic [DIST_W-1:0]        best_dist_r, best_dist_nxt;
  logic [FACE_W-1:0]        item_face_r, item_face_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [FACE_W-1:0]        nbr_r, nbr_nxt;
  logic                     nvis_r, nvis_nxt;
  logic                     nreach_r, nreach_nxt;
  logic [DIST_W-1:0]        ndist_r, ndist_nxt;
  logic [DIFF_W-1:0]        ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [SQ_W-1:0]          prod_r, prod_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]         face_count_r, face_count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gsd_out_t                 out_data_r, out_data_nxt;

  logic                     bari_we;
  logic [FACE_W-1:0]        bari_waddr, bari_raddr;
  logic [BARI_W-1:0]        bari_wdata, bari_rdata;
  logic                     nb_we;
  logic [NB_ADDR_W-1:0]     nb_waddr, nb_raddr;
  logic [NB_ENT_W-1:0]      nb_wdata, nb_rdata;
  logic                     dist_we;
  logic [FACE_W-1:0]        dist_waddr, dist_raddr;
  dist_ent_t                dist_wdata, dist_rdata;

  sqrt_req_t                sq_req;
  sqrt_rsp_t                sq_rsp;

  logic [CNT_W-1:0]         fc;
  logic                     in_bad;
  logic                     accept;
  logic [DIFF_W-1:0]        mul_a;
  logic [DIST_W:0]          nd_sum;
  logic [DIST_W-1:0]        nd;
  logic signed [COORD_W-1:0] bx, by, bz;

  gsd_ram #(.WIDTH(BARI_W), .DEPTH(MAX_FACES)) u_bari_ram (
    .clk   (clk),
    .we    (bari_we),
    .waddr (bari_waddr),
    .wdata (bari_wdata),
    .raddr (bari_raddr),
    .rdata (bari_rdata)
  );

  gsd_ram #(.WIDTH(NB_ENT_W), .DEPTH(NB_DEPTH)) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (nb_wdata),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  gsd_ram #(.WIDTH(DENT_W), .DEPTH(MAX_FACES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  gsd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign fc        = (face_count_r > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES) : face_count_r;
  assign in_bad    = {1'b0, in_data.face_index} >= fc;
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bx = bari_rdata[3*COORD_W-1:2*COORD_W];
  assign by = bari_rdata[2*COORD_W-1:COORD_W];
  assign bz = bari_rdata[COORD_W-1:0];

  assign nd_sum = {1'b0, best_dist_r} + (DIST_W+1)'(sq_rsp.root);
  assign nd     = nd_sum[DIST_W] ? DIST_ONES : nd_sum[DIST_W-1:0];

  always_comb begin
    case (state_r)
      ST_SQ_X: mul_a = ax_r;
      ST_SQ_Y: mul_a = ay_r;
      ST_SQ_Z: mul_a = az_r;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    face_i_nxt     = face_i_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    best_face_nxt  = best_face_r;
    best_dist_nxt  = best_dist_r;
    item_face_nxt  = item_face_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    nbr_nxt        = nbr_r;
    nvis_nxt       = nvis_r;
    nreach_nxt     = nreach_r;
    ndist_nxt      = ndist_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    az_nxt         = az_r;
    prod_nxt       = SQ_W'(mul_a) * SQ_W'(mul_a);
    sum_nxt        = sum_r;
    face_count_nxt = cfg_valid ? cfg_data : face_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    bari_we    = 1'b0;
    bari_waddr = in_data.face_index;
    bari_wdata = {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    bari_raddr = best_face_r;
    nb_we      = 1'b0;
    nb_waddr   = {in_data.face_index, in_data.slot};
    nb_wdata   = {in_data.neighbor_valid, in_data.neighbor_index};
    nb_raddr   = {best_face_r, slot_r};
    dist_we    = 1'b0;
    dist_waddr = idx_r[FACE_W-1:0];
    dist_wdata = '{reached: 1'b0, visited: 1'b0, path_len: DIST_ONES};
    dist_raddr = face_i_r[FACE_W-1:0];
    sq_req     = '{start: 1'b0, radicand: sum_r};

    case (state_r)
      ST_CLEAR: begin
        nb_we    = 1'b1;
        nb_waddr = idx_r;
        nb_wdata = '0;
        dist_we  = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_face_nxt = in_data.face_index;
          out_data_nxt  = '{result_face: in_data.face_index, distance: '0,
                            reachable: 1'b0, status: in_bad};
          case (in_data.kind)
            KIND_LOAD_BARI: begin
              bari_we       = 1'b1;
              out_valid_nxt = 1'b1;
            end
            KIND_LOAD_NB: begin
              nb_we         = in_data.slot < SLOT_W'(MAX_NB);
              out_valid_nxt = 1'b1;
            end
            KIND_RUN: begin
              if (in_bad) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_RUN_CLR;
              end
            end
            KIND_READ: begin
              if (in_bad) begin
                out_valid_nxt = 1'b1;
              end else begin
                dist_raddr = in_data.face_index;
                state_nxt  = ST_READ_WAIT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{result_face: item_face_r, distance: dist_rdata.path_len,
                          reachable: dist_rdata.visited, status: 1'b0};
        state_nxt     = ST_IDLE;
      end
      ST_RUN_CLR: begin
        dist_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r[FACE_W-1:0] == '1) begin
          state_nxt = ST_RUN_START;
        end
      end
      ST_RUN_START: begin
        dist_we    = 1'b1;
        dist_waddr = item_face_r;
        dist_wdata = '{reached: 1'b1, visited: 1'b0, path_len: '0};
        face_i_nxt = '0;
        found_nxt  = 1'b0;
        state_nxt  = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (face_i_r == fc) begin
          if (found_r) begin
            state_nxt = ST_MARK;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{result_face: item_face_r, distance: '0,
                              reachable: 1'b1, status: 1'b0};
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (dist_rdata.reached && !dist_rdata.visited &&
            (!found_r || dist_rdata.path_len < best_dist_r)) begin
          found_nxt     = 1'b1;
          best_face_nxt = face_i_r[FACE_W-1:0];
          best_dist_nxt = dist_rdata.path_len;
        end
        face_i_nxt = face_i_r + 1'b1;
        state_nxt  = ST_SCAN_RD;
      end
      ST_MARK: begin
        dist_we    = 1'b1;
        dist_waddr = best_face_r;
        dist_wdata = '{reached: 1'b1, visited: 1'b1, path_len: best_dist_r};
        slot_nxt   = '0;
        state_nxt  = ST_CUR_WAIT;
      end
      ST_CUR_WAIT: begin
        cx_nxt    = bx;
        cy_nxt    = by;
        cz_nxt    = bz;
        state_nxt = ST_NB_RD;
      end
      ST_NB_RD: begin
        state_nxt = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        if (nb_rdata[FACE_W] && ({1'b0, nb_rdata[FACE_W-1:0]} < fc)) begin
          nbr_nxt    = nb_rdata[FACE_W-1:0];
          bari_raddr = nb_rdata[FACE_W-1:0];
          dist_raddr = nb_rdata[FACE_W-1:0];
          state_nxt  = ST_FETCH;
        end else if (slot_r == SLOT_W'(MAX_NB - 1)) begin
          face_i_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = ST_SCAN_RD;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = ST_NB_RD;
        end
      end
      ST_FETCH: begin
        nvis_nxt   = dist_rdata.visited;
        nreach_nxt = dist_rdata.reached;
        ndist_nxt  = dist_rdata.path_len;
        ax_nxt     = abs_diff(bx, cx_r);
        ay_nxt     = abs_diff(by, cy_r);
        az_nxt     = abs_diff(bz, cz_r);
        state_nxt  = ST_SQ_X;
      end
      ST_SQ_X: begin
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        sum_nxt   = SUM_W'(prod_r);
        state_nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        sum_nxt   = sum_r + SUM_W'(prod_r);
        state_nxt = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        sum_nxt   = sum_r + SUM_W'(prod_r);
        state_nxt = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sq_req.start = 1'b1;
        state_nxt    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sq_rsp.done) begin
          state_nxt = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (!nreach_r || nd < ndist_r) begin
          dist_we    = 1'b1;
          dist_waddr = nbr_r;
          dist_wdata = '{reached: 1'b1, visited: nvis_r, path_len: nd};
        end
        if (slot_r == SLOT_W'(MAX_NB - 1)) begin
          face_i_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = ST_SCAN_RD;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = ST_NB_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      face_i_r     <= '0;
      slot_r       <= '0;
      found_r      <= 1'b0;
      face_count_r <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      face_i_r     <= face_i_nxt;
      slot_r       <= slot_nxt;
      found_r      <= found_nxt;
      face_count_r <= face_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    best_face_r <= best_face_nxt;
    best_dist_r <= best_dist_nxt;
    item_face_r <= item_face_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    nbr_r       <= nbr_nxt;
    nvis_r      <= nvis_nxt;
    nreach_r    <= nreach_nxt;
    ndist_r     <= ndist_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ----- rtl/gsd_checker.sv -----
// port level checks for the shortest distance block and their bind
`include "graph_shortest_distance_top_assert.svh"

module gsd_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input gsd_pkg::gsd_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input gsd_pkg::gsd_out_t out_data
);
  import gsd_pkg::*;

  logic out_stall;
  logic load_acc;
  logic bad_clean;

  assign out_stall = out_valid && !out_ready;
  assign load_acc  = in_valid && in_ready &&
                     (in_data.kind == KIND_LOAD_BARI || in_data.kind == KIND_LOAD_NB);
  assign bad_clean = (out_data.distance == '0) && !out_data.reachable;

  `GSD_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data))
  `GSD_ASSERT(a_load_resp, clk, rst_n, load_acc |=> out_valid)
  `GSD_ASSERT(a_bad_zero, clk, rst_n, out_valid && out_data.status |-> bad_clean)
  `GSD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && !in_ready)

endmodule

bind graph_shortest_distance_top gsd_port_checker u_gsd_port_checker (.*);

// ----- verif/gsd_checker.sv -----
`timescale 1ns / 1ps
// checker that predicts and compares results of the shortest distance block
module gsd_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  gsd_pkg::gsd_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  gsd_pkg::gsd_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [gsd_pkg::CNT_W-1:0] cfg_data,
  output int                        err_count,
  output int                        pending
);
  import gsd_pkg::*;

  localparam longint unsigned DMAX = 64'h0000_0000_FFFF_FFFF;

  logic signed [COORD_W-1:0] bx [MAX_FACES];
  logic signed [COORD_W-1:0] by [MAX_FACES];
  logic signed [COORD_W-1:0] bz [MAX_FACES];
  logic [FACE_W-1:0]         nb_face [MAX_FACES*MAX_NB];
  bit                        nb_pres [MAX_FACES*MAX_NB];
  longint unsigned           face_dist [MAX_FACES];
  bit                        visited [MAX_FACES];
  bit                        reached [MAX_FACES];
  logic [CNT_W-1:0]          face_cnt = 1;
  gsd_out_t                  result_q [$];

  initial begin
    err_count = 0;
    for (int i = 0; i < MAX_FACES; i++) begin
      face_dist[i] = DMAX;
      visited[i] = 0;
      reached[i] = 0;
      bx[i] = '0;
      by[i] = '0;
      bz[i] = '0;
    end
    for (int i = 0; i < MAX_FACES*MAX_NB; i++) begin
      nb_pres[i] = 0;
      nb_face[i] = '0;
    end
  end

  assign pending = result_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_diff(logic signed [COORD_W-1:0] a,
                                               logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(unsigned'(d)) * longint'(unsigned'(d));
  endfunction

  function automatic longint unsigned edge_len(int a, int b);
    longint unsigned w;
    w = int_sqrt(sq_diff(bx[a], bx[b]) + sq_diff(by[a], by[b]) + sq_diff(bz[a], bz[b]));
    return (w > DMAX) ? DMAX : w;
  endfunction

  task automatic walk_from(int start, int fc);
    int cur, n, e;
    bit found;
    longint unsigned nd;
    for (int i = 0; i < MAX_FACES; i++) begin
      face_dist[i] = DMAX;
      visited[i] = 0;
      reached[i] = 0;
    end
    face_dist[start] = 0;
    reached[start] = 1;
    found = 1;
    while (found) begin
      found = 0;
      cur = 0;
      for (int i = 0; i < fc; i++) begin
        if (reached[i] && !visited[i] && (!found || face_dist[i] < face_dist[cur])) begin
          cur = i;
          found = 1;
        end
      end
      if (found) begin
        visited[cur] = 1;
        for (int s = 0; s < MAX_NB; s++) begin
          e = cur * MAX_NB + s;
          n = nb_face[e];
          if (nb_pres[e] && n < fc) begin
            nd = face_dist[cur] + edge_len(cur, n);
            if (nd > DMAX) nd = DMAX;
            if (!reached[n] || nd < face_dist[n]) begin
              face_dist[n] = nd;
              reached[n] = 1;
            end
          end
        end
      end
    end
  endtask

  task automatic predict_result(gsd_in_t it, output gsd_out_t r);
    int fc, f, e;
    bit bad;
    fc = (face_cnt > MAX_FACES) ? MAX_FACES : int'(face_cnt);
    f = it.face_index;
    bad = f >= fc;
    r = '0;
    r.result_face = it.face_index;
    r.status = bad;
    case (it.kind)
      KIND_LOAD_BARI: begin
        bx[f] = it.coord_x;
        by[f] = it.coord_y;
        bz[f] = it.coord_z;
      end
      KIND_LOAD_NB: begin
        if (it.slot < MAX_NB) begin
          e = f * MAX_NB + it.slot;
          nb_face[e] = it.neighbor_index;
          nb_pres[e] = it.neighbor_valid;
        end
      end
      KIND_RUN: begin
        if (!bad) begin
          walk_from(f, fc);
          r.reachable = 1'b1;
        end
      end
      default: begin
        if (!bad) begin
          r.distance = face_dist[f][DIST_W-1:0];
          r.reachable = visited[f];
        end
      end
    endcase
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: mismatch %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    gsd_out_t r, want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_result(in_data, r);
        result_q = {result_q, r};
      end
      if (cfg_valid && cfg_ready) face_cnt = cfg_data;
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transaction face %0d", $realtime,
                   out_data.result_face);
        end else begin
          want = result_q.pop_front();
          check_field("result_face", want.result_face, out_data.result_face);
          check_field("distance", want.distance, out_data.distance);
          check_field("reachable", want.reachable, out_data.reachable);
          check_field("status", want.status, out_data.status);
        end
      end
    end
  end

endmodule

// ----- verif/tb_graph_shortest_distance_top.sv -----
`timescale 1ns / 1ps
// testbench top: stimulus, flow control and verdict for the shortest distance block
module tb_graph_shortest_distance_top;
  import gsd_pkg::*;

  localparam longint LIMIT = 40_000_000;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  gsd_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 0;
  gsd_out_t         out_data;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = 1;

  int     err_count, pending;
  int     cur_fc = 1;
  int     gap = 0;
  bit     quiet = 0;
  bit     hold_req = 0;
  int     n_items = 0, n_runs = 0, n_reads = 0;
  longint cycles = 0;

  graph_shortest_distance_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  gsd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side with one long hold-off
  always @(posedge clk) begin
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  task automatic send(gsd_in_t it, bit lower);
    if (gap > 0) repeat (gap) @(posedge clk);
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (it.kind == KIND_RUN) n_runs++;
    if (it.kind == KIND_READ) n_reads++;
    if (lower || (!quiet && $urandom_range(99) < 6)) begin
      in_valid <= 0;
      gap = lower ? 0 : $urandom_range(1, 5);
    end else begin
      gap = 0;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_faces(int v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    cur_fc = v;
  endtask

  function automatic gsd_in_t mk(kind_t k, int f);
    gsd_in_t it;
    it = '0;
    it.kind = k;
    it.face_index = FACE_W'(f);
    return it;
  endfunction

  function automatic gsd_in_t mk_bari(int f, int x, int y, int z);
    gsd_in_t it;
    it = mk(KIND_LOAD_BARI, f);
    it.coord_x = COORD_W'(x);
    it.coord_y = COORD_W'(y);
    it.coord_z = COORD_W'(z);
    return it;
  endfunction

  function automatic gsd_in_t mk_nb(int f, int s, int n, bit v);
    gsd_in_t it;
    it = mk(KIND_LOAD_NB, f);
    it.slot = SLOT_W'(s);
    it.neighbor_index = FACE_W'(n);
    it.neighbor_valid = v;
    return it;
  endfunction

  // neighbors stay inside the loaded area or far above any face count used for runs
  function automatic int pick_neighbor();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(0, 63);
    if (r < 90) return $urandom_range(1000, 1023);
    return (r < 95) ? 0 : 1023;
  endfunction

  function automatic int pick_face();
    if ($urandom_range(99) < 85) return $urandom_range(0, cur_fc - 1 < 63 ? cur_fc - 1 : 63);
    return $urandom_range(0, 1023);
  endfunction

  function automatic gsd_in_t rand_item();
    gsd_in_t it;
    int r;
    r = $urandom_range(99);
    if (r < 3 && cur_fc <= 64) begin
      it = mk(KIND_RUN, pick_face());
    end else if (r < 38) begin
      it = mk(KIND_READ, pick_face());
    end else if (r < 58) begin
      it = mk_bari(($urandom_range(99) < 80) ? $urandom_range(0, 63) : $urandom_range(0, 1023),
                   $urandom, $urandom, $urandom);
    end else begin
      it = mk_nb($urandom_range(0, 63), $urandom_range(0, 15), pick_neighbor(),
                 $urandom_range(0, 1));
    end
    return it;
  endfunction

  initial begin
    int fcs[7] = '{8, 1, 16, 1024, 64, 5, 12};
    int per_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // baricenters for the whole graph area
    for (int f = 0; f < 64; f++)
      send(mk_bari(f, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768), f == 63);
    set_faces(8);
    send(mk_bari(1023, 24'h7FFFFF, 24'h800000, 24'h7FFFFF), 0);
    send(mk_bari(7, 24'h800000, 24'h7FFFFF, 24'h800000), 0);
    send(mk_bari(6, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 0);
    send(mk_nb(0, 0, 1, 1), 0);
    send(mk_nb(1, 0, 2, 1), 0);
    send(mk_nb(0, 11, 2, 1), 0);
    send(mk_nb(2, 3, 7, 1), 0);
    send(mk_nb(7, 1, 6, 1), 0);
    send(mk_nb(2, 5, 1023, 1), 0);
    send(mk_nb(1, 12, 5, 1), 0);
    send(mk_nb(1, 15, 5, 1), 0);
    send(mk_nb(3, 0, 4, 0), 0);
    send(mk_nb(1023, 11, 1023, 1), 0);
    send(mk(KIND_RUN, 9), 0);
    send(mk(KIND_RUN, 1023), 0);
    send(mk(KIND_RUN, 0), 0);
    send(mk(KIND_READ, 0), 0);
    send(mk(KIND_READ, 2), 0);
    send(mk(KIND_READ, 6), 0);
    send(mk(KIND_READ, 4), 0);
    send(mk(KIND_READ, 1023), 0);
    send(mk(KIND_RUN, 7), 0);
    send(mk(KIND_READ, 0), 1);
    per_phase = (1450 - 87) / 7;
    for (int p = 0; p < 7; p++) begin
      set_faces(fcs[p]);
      quiet = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        if (p == 3 && i == 20) hold_req = 1;
        send(rand_item(), i == per_phase - 1);
      end
    end
    quiet = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d items (%0d runs, %0d reads) over face counts 1 to 1024",
             n_items, n_runs, n_reads);
    if (err_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gsd_pkg.sv
rtl/gsd_ram.sv
rtl/gsd_sqrt.sv
rtl/graph_shortest_distance_top.sv
rtl/gsd_checker.sv
verif/gsd_checker.sv
verif/tb_graph_shortest_distance_top.sv
